// ===== rtl/core/cct_pkg.sv =====
// ----------------------------------------------------------------------------
// cct_pkg
// shared types, widths, constants and helper functions of the colour
// threshold centroid tracker
// ----------------------------------------------------------------------------
`default_nettype none

package cct_pkg;

   // frame size limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   // field widths
   localparam int COLOUR_W    = 8;
   localparam int RGB_W       = 3 * COLOUR_W;
   localparam int SIZE_W      = 11;
   localparam int GAIN_W      = 32;
   localparam int ERR_W       = 32;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;

   // internal widths
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);
   localparam int POS_W       = (COL_W > ROW_W) ? COL_W : ROW_W;
   localparam int HALF_W      = POS_W;
   localparam int CNT_W       = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int SUM_W       = POS_W + CNT_W;
   localparam int NUM_W       = HALF_W + CNT_W;
   localparam int PROD_W      = GAIN_W + NUM_W;
   localparam int ROUND_SHIFT = 8;
   localparam int DIVIDEND_W  = PROD_W + 1;
   localparam int DIVISOR_W   = CNT_W + ROUND_SHIFT;
   localparam int STEP_W      = $clog2(DIVIDEND_W);

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CAP_LOW   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAP_HIGH  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TUBE_LOW  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TUBE_HIGH = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN      = 3'd6;

   // register reset values
   localparam logic [RGB_W-1:0]  CAP_LOW_RESET   = 24'h823232;
   localparam logic [RGB_W-1:0]  CAP_HIGH_RESET  = 24'hFF8C78;
   localparam logic [RGB_W-1:0]  TUBE_LOW_RESET  = 24'hC8C8C8;
   localparam logic [RGB_W-1:0]  TUBE_HIGH_RESET = 24'hFFFFFF;
   localparam logic [SIZE_W-1:0] WIDTH_RESET     = 11'd640;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET    = 11'd400;
   localparam logic [GAIN_W-1:0] GAIN_RESET      = 32'd5497799;

   // recolouring
   localparam logic [COLOUR_W-1:0] TUBE_GREEN = 8'd255;
   localparam logic [COLOUR_W-1:0] CAP_GREEN  = 8'd128;

   // saturation limits, as magnitudes
   localparam logic [DIVIDEND_W-1:0] NEG_LIMIT = DIVIDEND_W'(1) << (ERR_W - 1);
   localparam logic [DIVIDEND_W-1:0] POS_LIMIT = NEG_LIMIT - DIVIDEND_W'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HALF,
      ST_DIFF,
      ST_GAIN,
      ST_BIAS,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef enum logic {
      AXIS_ROW,
      AXIS_COL
   } axis_type;

   typedef struct packed {
      logic     accept;
      axis_type axis;
      logic     calc_half;
      logic     calc_diff;
      logic     calc_gain;
      logic     div_start;
      logic     store_err;
      logic     finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic last;
      logic empty;
      logic div_busy;
   } ctrl_status_type;

   // inclusive colour box test, bounds packed red, green, blue
   function automatic logic in_box(input logic [RGB_W-1:0] lo,
                                   input logic [RGB_W-1:0] hi,
                                   input logic [COLOUR_W-1:0] r,
                                   input logic [COLOUR_W-1:0] g,
                                   input logic [COLOUR_W-1:0] b);
      logic ok_r, ok_g, ok_b;
      ok_r = (r >= lo[3*COLOUR_W-1:2*COLOUR_W]) && (r <= hi[3*COLOUR_W-1:2*COLOUR_W]);
      ok_g = (g >= lo[2*COLOUR_W-1:COLOUR_W]) && (g <= hi[2*COLOUR_W-1:COLOUR_W]);
      ok_b = (b >= lo[COLOUR_W-1:0]) && (b <= hi[COLOUR_W-1:0]);
      return ok_r && ok_g && ok_b;
   endfunction

   // zero acts as one, anything above the limit acts as the limit
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input int limit);
      logic [SIZE_W-1:0] res;
      if (v == '0) begin
         res = SIZE_W'(1);
      end else if (int'(v) > limit) begin
         res = SIZE_W'(limit);
      end else begin
         res = v;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cct_req_if.sv =====
// ----------------------------------------------------------------------------
// cct_req_if
// pixel channel: valid, ready and one bgr pixel with its frame start flag
// ----------------------------------------------------------------------------
`default_nettype none

interface cct_req_if;
   logic                          valid;
   logic                          ready;
   logic                          frame_start;
   logic [cct_pkg::COLOUR_W-1:0]  pixel_blue;
   logic [cct_pkg::COLOUR_W-1:0]  pixel_green;
   logic [cct_pkg::COLOUR_W-1:0]  pixel_red;

   modport source (output valid, frame_start, pixel_blue, pixel_green, pixel_red,
                   input ready);
   modport sink   (input valid, frame_start, pixel_blue, pixel_green, pixel_red,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cct_rsp_if.sv =====
// ----------------------------------------------------------------------------
// cct_rsp_if
// result channel: recoloured pixel plus the end of frame centroid errors
// ----------------------------------------------------------------------------
`default_nettype none

interface cct_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [cct_pkg::COLOUR_W-1:0]       out_blue;
   logic [cct_pkg::COLOUR_W-1:0]       out_green;
   logic [cct_pkg::COLOUR_W-1:0]       out_red;
   logic                               frame_done;
   logic                               no_target;
   logic signed [cct_pkg::ERR_W-1:0]   error_row;
   logic signed [cct_pkg::ERR_W-1:0]   error_col;

   modport source (output valid, out_blue, out_green, out_red, frame_done, no_target,
                          error_row, error_col,
                   input ready);
   modport sink   (input valid, out_blue, out_green, out_red, frame_done, no_target,
                         error_row, error_col,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/core/color_threshold_centroid_tracker.sv =====
// ----------------------------------------------------------------------------
// color_threshold_centroid_tracker
// colour box recolouring of a bgr pixel stream with tube centroid errors
// ----------------------------------------------------------------------------
// Pixels arrive in raster order on req and leave recoloured on rsp, one
// result per pixel: tube pixels become pure green, cap-only pixels dark green,
// the rest pass unchanged. Every pixel but the last of a frame that held a tube
// pixel is taken and answered at one per clock while rsp is ready, the result
// register letting the next pixel in as the previous result is taken. The last
// pixel of a frame that held a tube pixel holds the input off until its result
// appears: for each axis a multiply, a subtract, the gain multiply and a
// 64-step radix-2 divider run, then a finish state publishes the result. The
// errors are gain * (size/2 - mean position) / 256 in signed Q8.24 metres,
// rounded to nearest and saturated; a frame with no tube pixel flags
// no_target with zero errors, at full rate.
// Write the registers only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module color_threshold_centroid_tracker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   cct_req_if.sink                                req,
   cct_rsp_if.source                              rsp,
   input  wire logic                              csr_we,
   input  wire logic [cct_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [cct_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // command and status between the sequencer and the datapath
   cct_pkg::ctrl_cmd_type     cmd;
   cct_pkg::ctrl_status_type  status;

   // handshakes and the end of frame sequence
   cct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // registers, classification, accumulators and error arithmetic
   cct_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .frame_start (req.frame_start),
      .pixel_blue  (req.pixel_blue),
      .pixel_green (req.pixel_green),
      .pixel_red   (req.pixel_red),
      .cmd         (cmd),
      .status      (status),
      .out_blue    (rsp.out_blue),
      .out_green   (rsp.out_green),
      .out_red     (rsp.out_red),
      .frame_done  (rsp.frame_done),
      .no_target   (rsp.no_target),
      .error_row   (rsp.error_row),
      .error_col   (rsp.error_col)
   );

endmodule

`default_nettype wire

// ===== rtl/core/cct_div.sv =====
// ----------------------------------------------------------------------------
// cct_div
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module cct_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [cct_pkg::DIVIDEND_W-1:0]    dividend,
   input  wire logic [cct_pkg::DIVISOR_W-1:0]     divisor,
   output logic                                   busy,
   output logic [cct_pkg::DIVIDEND_W-1:0]         quotient
);

   logic                               busy_ff, busy_in;
   logic [cct_pkg::STEP_W-1:0]         step_ff, step_in;
   logic [cct_pkg::DIVISOR_W-1:0]      rem_ff, rem_in;
   logic [cct_pkg::DIVIDEND_W-1:0]     quo_ff, quo_in;
   logic [cct_pkg::DIVISOR_W-1:0]      dvs_ff, dvs_in;
   logic [cct_pkg::DIVISOR_W:0]        trial;
   logic [cct_pkg::DIVISOR_W:0]        trial_diff;
   logic                               fits;

   // shift in the next dividend bit and try the subtract
   always_comb begin
      trial      = {rem_ff, quo_ff[cct_pkg::DIVIDEND_W-1]};
      fits       = trial >= {1'b0, dvs_ff};
      trial_diff = trial - {1'b0, dvs_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = cct_pkg::STEP_W'(cct_pkg::DIVIDEND_W - 1);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? trial_diff[cct_pkg::DIVISOR_W-1:0] : trial[cct_pkg::DIVISOR_W-1:0];
         quo_in  = {quo_ff[cct_pkg::DIVIDEND_W-2:0], fits};
         if (step_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff - cct_pkg::STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

   a_start_busy : assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && (step_ff == cct_pkg::STEP_W'(cct_pkg::DIVIDEND_W - 1)))
      else $error("divider did not start a full run");

   a_run_ends : assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && (step_ff == '0)) |=> !busy_ff)
      else $error("divider ran past its last step");

endmodule

`default_nettype wire

// ===== rtl/core/cct_ctrl.sv =====
// ----------------------------------------------------------------------------
// cct_ctrl
// controller: channel handshakes and the end of frame computation sequence
// ----------------------------------------------------------------------------
`default_nettype none

module cct_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   input  wire cct_pkg::ctrl_status_type  status,
   output cct_pkg::ctrl_cmd_type          cmd
);

   cct_pkg::state_type  state_ff, state_in;
   cct_pkg::axis_type   axis_ff, axis_in;
   logic                out_valid_ff, out_valid_in;
   logic                accept;
   logic                axis_done;

   // a pixel is taken only when the result register is free or being drained
   assign req_ready = (state_ff == cct_pkg::ST_IDLE) && (!out_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign axis_done = (state_ff == cct_pkg::ST_DIV) && !status.div_busy;

   // next state
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      unique case (state_ff)
         cct_pkg::ST_IDLE: begin
            if (accept && status.last && !status.empty) begin
               state_in = cct_pkg::ST_HALF;
               axis_in  = cct_pkg::AXIS_ROW;
            end
         end
         cct_pkg::ST_HALF:   state_in = cct_pkg::ST_DIFF;
         cct_pkg::ST_DIFF:   state_in = cct_pkg::ST_GAIN;
         cct_pkg::ST_GAIN:   state_in = cct_pkg::ST_BIAS;
         cct_pkg::ST_BIAS:   state_in = cct_pkg::ST_DIV;
         cct_pkg::ST_DIV: begin
            if (!status.div_busy) begin
               if (axis_ff == cct_pkg::AXIS_ROW) begin
                  state_in = cct_pkg::ST_HALF;
                  axis_in  = cct_pkg::AXIS_COL;
               end else begin
                  state_in = cct_pkg::ST_FINISH;
               end
            end
         end
         cct_pkg::ST_FINISH: state_in = cct_pkg::ST_IDLE;
         default:            state_in = cct_pkg::ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd.accept    = accept;
      cmd.axis      = axis_ff;
      cmd.calc_half = (state_ff == cct_pkg::ST_HALF);
      cmd.calc_diff = (state_ff == cct_pkg::ST_DIFF);
      cmd.calc_gain = (state_ff == cct_pkg::ST_GAIN);
      cmd.div_start = (state_ff == cct_pkg::ST_BIAS);
      cmd.store_err = axis_done;
      cmd.finish    = (state_ff == cct_pkg::ST_FINISH);
   end

   // result valid: the last pixel of a frame with a target waits for the errors
   always_comb begin
      priority if (accept) begin
         out_valid_in = !(status.last && !status.empty);
      end else if (state_ff == cct_pkg::ST_FINISH) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cct_pkg::ST_IDLE;
         axis_ff      <= cct_pkg::AXIS_ROW;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      accept |-> (!out_valid_ff || rsp_ready))
      else $error("pixel taken over a pending result");

   a_quiet_while_busy : assert property (@(posedge clock) disable iff (reset)
      (state_ff != cct_pkg::ST_IDLE) |-> !out_valid_ff)
      else $error("result shown before the errors are ready");

   a_finish_shows : assert property (@(posedge clock) disable iff (reset)
      (state_ff == cct_pkg::ST_FINISH) |=> out_valid_ff && (state_ff == cct_pkg::ST_IDLE))
      else $error("finished frame result not presented");

endmodule

`default_nettype wire

// ===== rtl/core/cct_datapath.sv =====
// ----------------------------------------------------------------------------
// cct_datapath
// registers, pixel classification, accumulators, centroid error arithmetic
// and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module cct_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [cct_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [cct_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire logic                                frame_start,
   input  wire logic [cct_pkg::COLOUR_W-1:0]        pixel_blue,
   input  wire logic [cct_pkg::COLOUR_W-1:0]        pixel_green,
   input  wire logic [cct_pkg::COLOUR_W-1:0]        pixel_red,
   input  wire cct_pkg::ctrl_cmd_type               cmd,
   output cct_pkg::ctrl_status_type                 status,
   output logic [cct_pkg::COLOUR_W-1:0]             out_blue,
   output logic [cct_pkg::COLOUR_W-1:0]             out_green,
   output logic [cct_pkg::COLOUR_W-1:0]             out_red,
   output logic                                     frame_done,
   output logic                                     no_target,
   output logic signed [cct_pkg::ERR_W-1:0]         error_row,
   output logic signed [cct_pkg::ERR_W-1:0]         error_col
);

   // configuration
   logic [cct_pkg::RGB_W-1:0]   cap_low_ff, cap_high_ff, tube_low_ff, tube_high_ff;
   logic [cct_pkg::SIZE_W-1:0]  width_ff, height_ff;
   logic [cct_pkg::GAIN_W-1:0]  gain_ff;
   logic [cct_pkg::SIZE_W-1:0]  w_eff, h_eff;

   // frame state
   logic [cct_pkg::COL_W-1:0]   col_ff, col_in, col_cur;
   logic [cct_pkg::ROW_W-1:0]   row_ff, row_in, row_cur;
   logic [cct_pkg::CNT_W-1:0]   cnt_ff, cnt_cur, cnt_next;
   logic [cct_pkg::SUM_W-1:0]   col_sum_ff, col_sum_cur, col_sum_next;
   logic [cct_pkg::SUM_W-1:0]   row_sum_ff, row_sum_cur, row_sum_next;
   logic                        is_tube, is_cap, row_end, last;

   // error arithmetic
   logic [cct_pkg::HALF_W-1:0]      half_sel;
   logic [cct_pkg::SUM_W-1:0]       sum_sel;
   logic [cct_pkg::NUM_W-1:0]       hc_ff;
   logic [cct_pkg::NUM_W-1:0]       num_ff;
   logic                            neg_ff;
   logic [cct_pkg::PROD_W-1:0]      prod_ff;
   logic [cct_pkg::DIVIDEND_W-1:0]  dividend;
   logic [cct_pkg::DIVISOR_W-1:0]   divisor;
   logic [cct_pkg::DIVIDEND_W-1:0]  quotient;
   logic                            div_busy;
   logic [cct_pkg::ERR_W-1:0]       err_sat;

   // result register
   logic [cct_pkg::COLOUR_W-1:0]    blue_ff, green_ff, red_ff;
   logic [cct_pkg::COLOUR_W-1:0]    blue_in, green_in, red_in;
   logic                            done_ff, none_ff;
   logic [cct_pkg::ERR_W-1:0]       err_row_ff, err_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_low_ff   <= cct_pkg::CAP_LOW_RESET;
         cap_high_ff  <= cct_pkg::CAP_HIGH_RESET;
         tube_low_ff  <= cct_pkg::TUBE_LOW_RESET;
         tube_high_ff <= cct_pkg::TUBE_HIGH_RESET;
         width_ff     <= cct_pkg::WIDTH_RESET;
         height_ff    <= cct_pkg::HEIGHT_RESET;
         gain_ff      <= cct_pkg::GAIN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            cct_pkg::CSR_CAP_LOW:   cap_low_ff   <= csr_wdata[cct_pkg::RGB_W-1:0];
            cct_pkg::CSR_CAP_HIGH:  cap_high_ff  <= csr_wdata[cct_pkg::RGB_W-1:0];
            cct_pkg::CSR_TUBE_LOW:  tube_low_ff  <= csr_wdata[cct_pkg::RGB_W-1:0];
            cct_pkg::CSR_TUBE_HIGH: tube_high_ff <= csr_wdata[cct_pkg::RGB_W-1:0];
            cct_pkg::CSR_WIDTH:     width_ff     <= csr_wdata[cct_pkg::SIZE_W-1:0];
            cct_pkg::CSR_HEIGHT:    height_ff    <= csr_wdata[cct_pkg::SIZE_W-1:0];
            cct_pkg::CSR_GAIN:      gain_ff      <= csr_wdata[cct_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   assign w_eff = cct_pkg::clamp_size(width_ff, cct_pkg::MAX_WIDTH);
   assign h_eff = cct_pkg::clamp_size(height_ff, cct_pkg::MAX_HEIGHT);

   // pixel classification and accumulation; frame start clears first
   always_comb begin
      col_cur     = frame_start ? '0 : col_ff;
      row_cur     = frame_start ? '0 : row_ff;
      cnt_cur     = frame_start ? '0 : cnt_ff;
      col_sum_cur = frame_start ? '0 : col_sum_ff;
      row_sum_cur = frame_start ? '0 : row_sum_ff;

      is_tube = cct_pkg::in_box(tube_low_ff, tube_high_ff, pixel_red, pixel_green, pixel_blue);
      is_cap  = cct_pkg::in_box(cap_low_ff, cap_high_ff, pixel_red, pixel_green, pixel_blue);

      cnt_next     = cnt_cur + cct_pkg::CNT_W'(is_tube);
      col_sum_next = col_sum_cur + (is_tube ? cct_pkg::SUM_W'(col_cur) : '0);
      row_sum_next = row_sum_cur + (is_tube ? cct_pkg::SUM_W'(row_cur) : '0);

      row_end = (32'(col_cur) + 32'd1) >= 32'(w_eff);
      last    = row_end && ((32'(row_cur) + 32'd1) >= 32'(h_eff));

      if (last) begin
         col_in = '0;
         row_in = '0;
      end else if (row_end) begin
         col_in = '0;
         row_in = row_cur + cct_pkg::ROW_W'(1);
      end else begin
         col_in = col_cur + cct_pkg::COL_W'(1);
         row_in = row_cur;
      end

      if (is_tube) begin
         blue_in  = '0;
         green_in = cct_pkg::TUBE_GREEN;
         red_in   = '0;
      end else if (is_cap) begin
         blue_in  = '0;
         green_in = cct_pkg::CAP_GREEN;
         red_in   = '0;
      end else begin
         blue_in  = pixel_blue;
         green_in = pixel_green;
         red_in   = pixel_red;
      end
   end

   assign status.last     = last;
   assign status.empty    = (cnt_next == '0);
   assign status.div_busy = div_busy;

   // accumulators stay through the error sequence and clear when it ends
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         cnt_ff     <= '0;
         col_sum_ff <= '0;
         row_sum_ff <= '0;
      end else if (cmd.accept) begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         cnt_ff     <= cnt_next;
         col_sum_ff <= col_sum_next;
         row_sum_ff <= row_sum_next;
      end else if (cmd.finish) begin
         cnt_ff     <= '0;
         col_sum_ff <= '0;
         row_sum_ff <= '0;
      end
   end

   // gain * (half * count - sum) rounded by (. + 128 count) / (256 count)
   always_comb begin
      if (cmd.axis == cct_pkg::AXIS_ROW) begin
         half_sel = cct_pkg::HALF_W'(h_eff >> 1);
         sum_sel  = row_sum_ff;
      end else begin
         half_sel = cct_pkg::HALF_W'(w_eff >> 1);
         sum_sel  = col_sum_ff;
      end
      dividend = cct_pkg::DIVIDEND_W'(prod_ff)
               + (cct_pkg::DIVIDEND_W'(cnt_ff) << (cct_pkg::ROUND_SHIFT - 1));
      divisor  = {cnt_ff, {cct_pkg::ROUND_SHIFT{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (cmd.calc_half) begin
         hc_ff <= cct_pkg::NUM_W'(half_sel) * cct_pkg::NUM_W'(cnt_ff);
      end
      if (cmd.calc_diff) begin
         neg_ff <= cct_pkg::NUM_W'(sum_sel) > hc_ff;
         num_ff <= (cct_pkg::NUM_W'(sum_sel) > hc_ff) ? cct_pkg::NUM_W'(sum_sel) - hc_ff
                                                      : hc_ff - cct_pkg::NUM_W'(sum_sel);
      end
      if (cmd.calc_gain) begin
         prod_ff <= cct_pkg::PROD_W'(gain_ff) * cct_pkg::PROD_W'(num_ff);
      end
   end

   cct_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // saturate the magnitude and apply the sign
   always_comb begin
      if (neg_ff) begin
         if (quotient > cct_pkg::NEG_LIMIT) begin
            err_sat = cct_pkg::NEG_LIMIT[cct_pkg::ERR_W-1:0];
         end else begin
            err_sat = cct_pkg::ERR_W'(0) - quotient[cct_pkg::ERR_W-1:0];
         end
      end else begin
         if (quotient > cct_pkg::POS_LIMIT) begin
            err_sat = cct_pkg::POS_LIMIT[cct_pkg::ERR_W-1:0];
         end else begin
            err_sat = quotient[cct_pkg::ERR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         blue_ff    <= blue_in;
         green_ff   <= green_in;
         red_ff     <= red_in;
         done_ff    <= last;
         none_ff    <= last && (cnt_next == '0);
         err_row_ff <= '0;
         err_col_ff <= '0;
      end else if (cmd.store_err) begin
         if (cmd.axis == cct_pkg::AXIS_ROW) begin
            err_row_ff <= err_sat;
         end else begin
            err_col_ff <= err_sat;
         end
      end
   end

   assign out_blue   = blue_ff;
   assign out_green  = green_ff;
   assign out_red    = red_ff;
   assign frame_done = done_ff;
   assign no_target  = none_ff;
   assign error_row  = $signed(err_row_ff);
   assign error_col  = $signed(err_col_ff);

endmodule

`default_nettype wire
